// ----- design/dgdh_pkg.sv -----
// Package for the differential-drive command gate: widths, limits and codes.
// It stands alone and is used by every module of the block.
`default_nettype none
package dgdh_pkg;

  localparam int SpeedW = 22;
  localparam int InSpeedW = 20;
  localparam int AgeW = 24;
  localparam int ElapsedW = 10;
  localparam int WidthW = 16;
  localparam int CountW = 10;
  localparam int CfgIdxW = 4;

  localparam logic [AgeW-1:0] AGE_MAX = {AgeW{1'b1}};
  localparam logic [CountW-1:0] HOLD_REFRESH = 10'd64;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_WHEEL_WIDTH = 4'd0;
  localparam cfg_idx_t REG_TIMEOUT = 4'd1;
  localparam cfg_idx_t REG_ENABLED = 4'd2;
  localparam cfg_idx_t REG_LOCKED = 4'd3;

  typedef enum logic [1:0] {
    RSN_DRIVE = 2'd0,
    RSN_ENGAGE = 2'd1,
    RSN_REFRESH = 2'd2
  } reason_t;

  localparam logic [WidthW-1:0] WHEEL_WIDTH_RESET = 16'd4096;
  localparam logic [WidthW-1:0] TIMEOUT_RESET = 16'd1000;

endpackage
`default_nettype wire

// ----- design/dgdh_wheel_calc.sv -----
// Wheel speed calculation: linear speed minus and plus half the track width
// times the angular speed, rounded and saturated. Uses dgdh_pkg.
`default_nettype none
module dgdh_wheel_calc (
  input  wire logic signed [dgdh_pkg::InSpeedW-1:0] linear,
  input  wire logic signed [dgdh_pkg::InSpeedW-1:0] angular,
  input  wire logic        [dgdh_pkg::WidthW-1:0]   wheel_width,
  output logic signed      [dgdh_pkg::SpeedW-1:0]   left_wheel,
  output logic signed      [dgdh_pkg::SpeedW-1:0]   right_wheel
);
  import dgdh_pkg::*;

  logic signed [36:0] prod;
  logic signed [36:0] rounded;
  logic signed [23:0] term;
  logic signed [24:0] left_full;
  logic signed [24:0] right_full;

  function automatic logic [SpeedW-1:0] sat22(input logic [24:0] v);
    logic [SpeedW-1:0] r;
    if ((v[24:21] == 4'b0000) || (v[24:21] == 4'b1111)) begin
      r = v[SpeedW-1:0];
    end else if (v[24]) begin
      r = {1'b1, {(SpeedW-1){1'b0}}};
    end else begin
      r = {1'b0, {(SpeedW-1){1'b1}}};
    end
    return r;
  endfunction

  // Half the width is folded into the rounding shift of the Q.12 product.
  assign prod = 37'(angular) * 37'($signed({1'b0, wheel_width}));
  assign rounded = prod + 37'sd4096;
  assign term = rounded[36:13];
  assign left_full = {{5{linear[InSpeedW-1]}}, linear} - {term[23], term};
  assign right_full = {{5{linear[InSpeedW-1]}}, linear} + {term[23], term};
  assign left_wheel = sat22(left_full);
  assign right_wheel = sat22(right_full);

endmodule
`default_nettype wire

// ----- design/drive_gate_with_deadman_hold.sv -----
// Top level of the differential-drive command gate with dead man's switch and hold.
// Depends on dgdh_pkg and dgdh_wheel_calc.
//
// Use: each input transfer is either a speed command (cmd = 1) or a tick of
// elapsed time (cmd = 0). Every input transfer yields exactly one output
// transfer carrying send, reason, wheel speeds, command age and the stopped flag.
// Items are accepted on in_valid with in_stall low; results leave on out_valid
// with out_stall low. The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) is always ready; indexes beyond the register list are ignored.
// Each item passes through the input register, then through the speed multiplier and
// state update into the result register. Throughput is one item per cycle while the
// receiver takes results.
// When the receiver stalls, the result register holds, the input register fills
// and then in_stall rises until the result is taken.
// Reset clears both pipeline stages, the age, the flags and the refresh count,
// and loads the registers with their defaults (width 1.0 m, timeout 1000 ms,
// enabled, not locked).
`default_nettype none
module drive_gate_with_deadman_hold (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  cmd,
  input  wire logic signed [dgdh_pkg::InSpeedW-1:0]  linear,
  input  wire logic signed [dgdh_pkg::InSpeedW-1:0]  angular,
  input  wire logic        [dgdh_pkg::ElapsedW-1:0]  elapsed_ms,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic        [dgdh_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic        [dgdh_pkg::WidthW-1:0]    cfg_data,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       send,
  output logic             [1:0]                     reason,
  output logic signed      [dgdh_pkg::SpeedW-1:0]    left_wheel,
  output logic signed      [dgdh_pkg::SpeedW-1:0]    right_wheel,
  output logic             [dgdh_pkg::AgeW-1:0]      command_age,
  output logic                                       is_stopped
);
  import dgdh_pkg::*;

  logic [WidthW-1:0] wheel_width;
  logic [WidthW-1:0] drive_timeout_ms;
  logic drive_enabled;
  logic drive_locked;

  logic [AgeW-1:0] age_ms;
  logic moving_flag;
  logic stopped_flag;
  logic holding_flag;
  logic [CountW-1:0] refresh_count;

  logic s1_valid;
  logic s1_cmd;
  logic signed [InSpeedW-1:0] s1_linear;
  logic signed [InSpeedW-1:0] s1_angular;
  logic [ElapsedW-1:0] s1_elapsed;

  logic advance;
  logic step;

  logic signed [SpeedW-1:0] calc_left;
  logic signed [SpeedW-1:0] calc_right;

  logic [AgeW-1:0] age_ms_next;
  logic moving_flag_next;
  logic stopped_flag_next;
  logic holding_flag_next;
  logic [CountW-1:0] refresh_count_next;
  logic send_next;
  reason_t reason_next;
  logic signed [SpeedW-1:0] left_next;
  logic signed [SpeedW-1:0] right_next;

  logic [AgeW:0] age_sum;
  logic [AgeW-1:0] age_sat;
  logic trip;
  logic stopped_tick;
  logic hold_wanted;
  logic [CountW-1:0] count_inc;
  logic drive_ok;

  assign advance = !out_valid || !out_stall;
  assign step = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign cfg_ready = 1'b1;

  dgdh_wheel_calc u_wheel_calc (
    .linear      (s1_linear),
    .angular     (s1_angular),
    .wheel_width (wheel_width),
    .left_wheel  (calc_left),
    .right_wheel (calc_right)
  );

  always_comb begin
    drive_ok = drive_enabled && !drive_locked;
    age_sum = {1'b0, age_ms} + {{(AgeW + 1 - ElapsedW){1'b0}}, s1_elapsed};
    age_sat = age_sum[AgeW] ? AGE_MAX : age_sum[AgeW-1:0];
    trip = moving_flag && (drive_timeout_ms != '0) &&
           (age_sat > {{(AgeW - WidthW){1'b0}}, drive_timeout_ms});
    stopped_tick = stopped_flag || trip;
    hold_wanted = drive_enabled && (drive_locked || stopped_tick);
    count_inc = refresh_count + 1'b1;

    age_ms_next = age_ms;
    moving_flag_next = moving_flag;
    stopped_flag_next = stopped_flag;
    holding_flag_next = holding_flag;
    refresh_count_next = refresh_count;
    send_next = 1'b0;
    reason_next = RSN_DRIVE;
    left_next = '0;
    right_next = '0;

    if (s1_cmd) begin
      age_ms_next = '0;
      if (drive_ok) begin
        stopped_flag_next = 1'b0;
        moving_flag_next = (s1_linear != '0) || (s1_angular != '0);
        send_next = 1'b1;
        left_next = calc_left;
        right_next = calc_right;
      end
    end else begin
      age_ms_next = age_sat;
      moving_flag_next = moving_flag && !trip;
      stopped_flag_next = stopped_tick;
      if (!hold_wanted) begin
        holding_flag_next = 1'b0;
      end else if (holding_flag) begin
        if (count_inc >= HOLD_REFRESH) begin
          refresh_count_next = '0;
          send_next = 1'b1;
          reason_next = RSN_REFRESH;
        end else begin
          refresh_count_next = count_inc;
        end
      end else begin
        holding_flag_next = 1'b1;
        refresh_count_next = '0;
        moving_flag_next = 1'b0;
        send_next = 1'b1;
        reason_next = RSN_ENGAGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_width <= WHEEL_WIDTH_RESET;
      drive_timeout_ms <= TIMEOUT_RESET;
      drive_enabled <= 1'b1;
      drive_locked <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WHEEL_WIDTH: wheel_width <= cfg_data;
        REG_TIMEOUT:     drive_timeout_ms <= cfg_data;
        REG_ENABLED:     drive_enabled <= cfg_data[0];
        REG_LOCKED:      drive_locked <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd <= cmd;
      s1_linear <= linear;
      s1_angular <= angular;
      s1_elapsed <= elapsed_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age_ms <= '0;
      moving_flag <= 1'b0;
      stopped_flag <= 1'b0;
      holding_flag <= 1'b0;
      refresh_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (step) begin
        age_ms <= age_ms_next;
        moving_flag <= moving_flag_next;
        stopped_flag <= stopped_flag_next;
        holding_flag <= holding_flag_next;
        refresh_count <= refresh_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      send <= send_next;
      reason <= reason_next;
      left_wheel <= left_next;
      right_wheel <= right_next;
      command_age <= age_ms_next;
      is_stopped <= stopped_flag_next;
    end
  end

endmodule
`default_nettype wire

// ----- test/drive_gate_with_deadman_hold_test.sv -----
// Self-checking testbench for the drive command gate with dead man's switch and hold.
// Needs dgdh_pkg and drive_gate_with_deadman_hold; it predicts every result in line
// and compares each output transfer with the oldest prediction, field by field.
module drive_gate_with_deadman_hold_test;
  import dgdh_pkg::*;

  typedef struct packed {
    logic                cmd;
    logic [InSpeedW-1:0] lin;
    logic [InSpeedW-1:0] ang;
    logic [ElapsedW-1:0] el;
  } gate_item_t;

  typedef struct packed {
    logic              send;
    reason_t           reason;
    logic [SpeedW-1:0] left_spd;
    logic [SpeedW-1:0] right_spd;
    logic [AgeW-1:0]   age;
    logic              stopped;
  } wheel_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       cmd = 1'b0;
  logic signed [InSpeedW-1:0] linear = '0;
  logic signed [InSpeedW-1:0] angular = '0;
  logic [ElapsedW-1:0]        elapsed_ms = '0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CfgIdxW-1:0]         cfg_index = '0;
  logic [WidthW-1:0]          cfg_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       send;
  logic [1:0]                 reason;
  logic signed [SpeedW-1:0]   left_wheel;
  logic signed [SpeedW-1:0]   right_wheel;
  logic [AgeW-1:0]            command_age;
  logic                       is_stopped;

  drive_gate_with_deadman_hold dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .linear(linear), .angular(angular), .elapsed_ms(elapsed_ms),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_stall(out_stall), .send(send),
    .reason(reason), .left_wheel(left_wheel), .right_wheel(right_wheel),
    .command_age(command_age), .is_stopped(is_stopped)
  );

  always #5 clk = ~clk;

  gate_item_t    pending_items[$];
  wheel_result_t awaited_results[$];
  int            items_queued = 0;
  int            results_seen = 0;
  int            mismatches = 0;
  logic          item_taken = 1'b0;
  logic          cfg_taken = 1'b0;
  bit            fast_sender = 1'b0;
  int            holds_asked = 0;

  logic [WidthW-1:0] width_reg;
  logic [WidthW-1:0] timeout_reg;
  logic              enabled_reg;
  logic              locked_reg;
  logic [AgeW-1:0]   age_now;
  logic              moving_now;
  logic              stopped_now;
  logic              holding_now;
  logic [CountW-1:0] refresh_now;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [SpeedW-1:0] clamp_speed(input longint v);
    if (v > 2097151) return SpeedW'(2097151);
    if (v < -2097152) return SpeedW'(-2097152);
    return SpeedW'(v);
  endfunction

  task automatic apply_reg_write(input logic [CfgIdxW-1:0] idx, input logic [WidthW-1:0] d);
    case (idx)
      REG_WHEEL_WIDTH: width_reg = d;
      REG_TIMEOUT:     timeout_reg = d;
      REG_ENABLED:     enabled_reg = d[0];
      REG_LOCKED:      locked_reg = d[0];
      default: ;
    endcase
  endtask

  task automatic step_gate_model(input gate_item_t it, output wheel_result_t r);
    longint    lin;
    longint    ang;
    longint    term;
    logic [AgeW:0] sum;
    logic      hold_now;
    r = '0;
    if (it.cmd) begin
      age_now = '0;
      if (enabled_reg && !locked_reg) begin
        lin = $signed(it.lin);
        ang = $signed(it.ang);
        term = (ang * longint'(width_reg) + 4096) >>> 13;
        stopped_now = 1'b0;
        moving_now = (lin != 0) || (ang != 0);
        r.send = 1'b1;
        r.reason = RSN_DRIVE;
        r.left_spd = clamp_speed(lin - term);
        r.right_spd = clamp_speed(lin + term);
      end
    end else begin
      sum = {1'b0, age_now} + it.el;
      age_now = (sum > AGE_MAX) ? AGE_MAX : sum[AgeW-1:0];
      if (moving_now && timeout_reg != 0 && age_now > timeout_reg) begin
        moving_now = 1'b0;
        stopped_now = 1'b1;
      end
      hold_now = enabled_reg && (locked_reg || stopped_now);
      if (!hold_now) begin
        holding_now = 1'b0;
      end else if (holding_now) begin
        refresh_now = refresh_now + 1'b1;
        if (refresh_now >= HOLD_REFRESH) begin
          refresh_now = '0;
          r.send = 1'b1;
          r.reason = RSN_REFRESH;
        end
      end else begin
        holding_now = 1'b1;
        refresh_now = '0;
        moving_now = 1'b0;
        r.send = 1'b1;
        r.reason = RSN_ENGAGE;
      end
    end
    r.age = age_now;
    r.stopped = stopped_now;
  endtask

  always @(posedge clk) begin : watch
    wheel_result_t want;
    item_taken <= in_valid && in_stall === 1'b0;
    cfg_taken <= cfg_valid && cfg_ready === 1'b1;
    if (!rst) begin
      if (cfg_valid && cfg_ready === 1'b1) begin
        apply_reg_write(cfg_index, cfg_data);
      end
      if (in_valid && in_stall === 1'b0) begin
        step_gate_model({cmd, linear, angular, elapsed_ms}, want);
        awaited_results.push_back(want);
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          flag_mismatch("result with nothing expected", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          if (send !== want.send) flag_mismatch("send", send, want.send);
          if (reason !== want.reason) flag_mismatch("reason", reason, want.reason);
          if (left_wheel !== want.left_spd) begin
            flag_mismatch("left_wheel", left_wheel, $signed(want.left_spd));
          end
          if (right_wheel !== want.right_spd) begin
            flag_mismatch("right_wheel", right_wheel, $signed(want.right_spd));
          end
          if (command_age !== want.age) flag_mismatch("command_age", command_age, want.age);
          if (is_stopped !== want.stopped) begin
            flag_mismatch("is_stopped", is_stopped, want.stopped);
          end
        end
      end
    end
  end

  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : feed
    gate_item_t nxt;
    if (!in_valid || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        cmd <= nxt.cmd;
        linear <= nxt.lin;
        angular <= nxt.ang;
        elapsed_ms <= nxt.el;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = (fast_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  int          stall_age = 0;
  int          hold_left = 0;
  int          holds_served = 0;
  logic [15:0] stall_bits = '0;

  always @(negedge clk) begin
    if (hold_left == 0 && holds_served != holds_asked) begin
      holds_served++;
      hold_left = 300;
    end
    if (stall_age == 0) begin
      stall_age = $urandom_range(8, 64);
      case ($urandom_range(0, 3))
        0: stall_bits = '0;
        1: stall_bits = 16'($urandom);
        2: stall_bits = 16'($urandom & $urandom);
        default: stall_bits = 16'($urandom | $urandom);
      endcase
    end
    stall_age--;
    stall_bits = {stall_bits[14:0], stall_bits[15]};
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= stall_bits[0];
    end
  end

  function automatic logic [InSpeedW-1:0] pick_speed();
    case ($urandom_range(0, 7))
      0: return 20'h80000;
      1: return 20'h7FFFF;
      2: return '0;
      3: return 20'($urandom_range(1, 4096));
      4: return -20'($urandom_range(1, 4096));
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [ElapsedW-1:0] pick_elapsed();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 10'd1023;
      2: return 10'($urandom_range(1, 50));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic push_cmd(input logic [InSpeedW-1:0] lin, input logic [InSpeedW-1:0] ang);
    pending_items.push_back({1'b1, lin, ang, 10'($urandom)});
    items_queued++;
  endtask

  task automatic push_tick(input logic [ElapsedW-1:0] el);
    pending_items.push_back({1'b0, 20'($urandom), 20'($urandom), el});
    items_queued++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WidthW-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [WidthW-1:0] w, input logic [WidthW-1:0] t,
                           input logic en, input logic lk);
    write_reg(REG_WHEEL_WIDTH, w);
    write_reg(REG_TIMEOUT, t);
    write_reg(REG_ENABLED, {15'($urandom), en});
    write_reg(REG_LOCKED, {15'($urandom), lk});
    write_reg(4'($urandom_range(4, 15)), 16'($urandom));
  endtask

  task automatic settle();
    while (results_seen != items_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_traffic(input int n);
    int made;
    int run;
    int el_hi;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 7) == 0) push_cmd('0, '0);
        else push_cmd(pick_speed(), pick_speed());
        run = $urandom_range(1, 90);
        case ($urandom_range(0, 2))
          0: el_hi = 3;
          1: el_hi = 40;
          default: el_hi = 1023;
        endcase
        for (int k = 0; k < run; k++) push_tick(10'($urandom_range(0, el_hi)));
        made += run + 1;
      end else begin
        run = $urandom_range(1, 10);
        for (int k = 0; k < run; k++) begin
          if ($urandom_range(0, 1) == 1) push_cmd(pick_speed(), pick_speed());
          else push_tick(pick_elapsed());
        end
        made += run;
      end
    end
  endtask

  initial begin : stimulus
    width_reg = WHEEL_WIDTH_RESET;
    timeout_reg = TIMEOUT_RESET;
    enabled_reg = 1'b1;
    locked_reg = 1'b0;
    age_now = '0;
    moving_now = 1'b0;
    stopped_now = 1'b0;
    holding_now = 1'b0;
    refresh_now = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset defaults: rounding ties, a trip of the switch, engage and release of the hold.
    push_cmd('0, '0);
    push_cmd(20'h7FFFF, 20'h80000);
    push_cmd(20'h80000, 20'h7FFFF);
    push_cmd(20'd1, 20'd1);
    push_cmd(20'hFFFFF, 20'hFFFFF);
    push_tick(10'd1023);
    push_tick(10'd0);
    push_cmd('0, '0);
    push_tick(10'd1023);
    push_tick(10'd1023);
    settle();
    write_reg(REG_WHEEL_WIDTH, 16'hFFFF);
    write_reg(REG_TIMEOUT, '0);
    push_cmd(20'h7FFFF, 20'h7FFFF);
    push_cmd(20'h80000, 20'h7FFFF);
    push_cmd(20'd3, 20'h80000);
    push_tick(10'd1023);
    settle();
    write_reg(REG_LOCKED, 16'hFFFF);
    push_cmd(20'd100, 20'd100);
    push_tick(10'd5);
    push_tick(10'd5);
    settle();
    write_reg(REG_ENABLED, 16'hFFFE);
    push_tick(10'd1);
    push_cmd(20'd5, 20'd5);

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: load_regs(WHEEL_WIDTH_RESET, TIMEOUT_RESET, 1'b1, 1'b0);
        1: load_regs(16'hFFFF, 16'd1, 1'b1, 1'b0);
        2: load_regs('0, '0, 1'b1, 1'b0);
        3: load_regs(16'($urandom), 16'hFFFF, 1'b1, 1'b1);
        4: load_regs(16'($urandom), 16'($urandom_range(1, 3000)), 1'b0, 1'b0);
        5: load_regs(16'($urandom), 16'($urandom_range(1, 500)), 1'b0, 1'b1);
        6: load_regs(16'($urandom), 16'($urandom_range(1, 3000)), 1'b1, 1'b0);
        default: load_regs(16'($urandom), 16'($urandom_range(0, 4000)),
                           1'($urandom), 1'($urandom));
      endcase
      fast_sender = (p == 2);
      queue_traffic(110);
      if (p == 1 || p == 6) holds_asked++;
    end

    // A long run of ticks with no command keeps the hold refreshing.
    settle();
    load_regs(WHEEL_WIDTH_RESET, 16'd1, 1'b1, 1'b0);
    fast_sender = 1'b1;
    push_cmd(20'd4096, '0);
    for (int k = 0; k < 120; k++) begin
      if (k % 16 == 0) push_tick(pick_elapsed());
      else push_tick(10'd1023);
    end
    push_cmd(pick_speed(), pick_speed());
    push_tick(10'd1);

    settle();
    repeat (8) @(negedge clk);
    if (awaited_results.size() != 0) begin
      flag_mismatch("results never delivered", 0, awaited_results.size());
    end
    if (mismatches == 0) begin
      $display("drive_gate_with_deadman_hold_test passed");
    end else begin
      $display("drive_gate_with_deadman_hold_test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("drive_gate_with_deadman_hold_test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
design/dgdh_pkg.sv
design/dgdh_wheel_calc.sv
design/drive_gate_with_deadman_hold.sv
test/drive_gate_with_deadman_hold_test.sv
